// ===== design/blvm_pkg.sv =====
// Shared types and constants for the battery low-voltage monitor.
package blvm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned MV_W        = 13;
  localparam int unsigned LIMIT_W     = 7;
  localparam int unsigned TICKS_W     = 8;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  // Converter full scale in millivolts and its width in bits.
  localparam int unsigned VREF_MV      = 3300;
  localparam int unsigned VREF_W       = 12;
  localparam int unsigned PROD_W       = SAMPLE_BITS + VREF_W;

  // Filter gain 1/5: floor(x / 5) == (x * RECIP5) >> RECIP5_SHIFT for x < 16384.
  localparam int unsigned DIFF_W       = MV_W + 1;
  localparam int unsigned RECIP5       = 13108;
  localparam int unsigned RECIP5_W     = 15;
  localparam int unsigned RECIP5_SHIFT = 16;
  localparam int unsigned QPROD_W      = DIFF_W + RECIP5_W;

  localparam logic [MV_W-1:0]    VOLTAGE_RESET   = 13'd4000;
  localparam logic [MV_W-1:0]    LOW_THR_RESET   = 13'd3700;
  localparam logic [MV_W-1:0]    HIGH_THR_RESET  = 13'd3750;
  localparam logic [MV_W-1:0]    FLOOR_RESET     = 13'd3400;
  localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET  = 7'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOW_THRESHOLD  = 2'd0,
    CFG_HIGH_THRESHOLD = 2'd1,
    CFG_FLOOR          = 2'd2,
    CFG_DEBOUNCE_LIMIT = 2'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic                   in_flight;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0] filtered_mv;
    logic            batt_low;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0]    low_threshold_mv;
    logic [MV_W-1:0]    high_threshold_mv;
    logic [MV_W-1:0]    floor_mv;
    logic [LIMIT_W-1:0] debounce_limit;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]    voltage_mv;
    logic [TICKS_W-1:0] low_ticks;
    logic [TICKS_W-1:0] ok_ticks;
    logic               batt_low_flag;
  } mon_state_t;

endpackage

// ===== design/blvm_step.sv =====
// One tick of the monitor: scaling, low-pass filter and debounced band decision.
module blvm_step import blvm_pkg::*; (
  input  in_item_t   item,
  input  cfg_t       cfg,
  input  mon_state_t cur,
  output mon_state_t nxt
);

  logic [PROD_W-1:0]      scale_prod;
  logic [MV_W-1:0]        meas_mv;
  logic signed [DIFF_W-1:0] diff;
  logic                   diff_neg;
  logic [DIFF_W-1:0]      div_in;
  logic [QPROD_W-1:0]     div_prod;
  logic [MV_W-1:0]        step_mv;
  logic [MV_W-1:0]        volt_nxt;
  logic                   in_low_band;
  logic                   in_ok_band;
  logic [TICKS_W-1:0]     low_inc;
  logic [TICKS_W-1:0]     ok_inc;
  logic [TICKS_W-1:0]     limit_ext;

  assign scale_prod = {{VREF_W{1'b0}}, item.adc_sample} * PROD_W'(VREF_MV);
  assign meas_mv    = {scale_prod[PROD_W-1 -: VREF_W], 1'b0};

  assign diff     = $signed({1'b0, meas_mv}) - $signed({1'b0, cur.voltage_mv});
  assign diff_neg = diff[DIFF_W-1];
  // A negative difference is floored by dividing its magnitude plus four.
  assign div_in   = diff_neg ? (DIFF_W'(4) - $unsigned(diff)) : $unsigned(diff);
  assign div_prod = {{RECIP5_W{1'b0}}, div_in} * QPROD_W'(RECIP5);
  assign step_mv  = div_prod[RECIP5_SHIFT +: MV_W];

  // The new voltage lies between the old one and the measurement, so no wrap occurs.
  assign volt_nxt = diff_neg ? (cur.voltage_mv - step_mv) : (cur.voltage_mv + step_mv);

  assign in_low_band = (volt_nxt < cfg.low_threshold_mv) && (volt_nxt > cfg.floor_mv);
  assign in_ok_band  = volt_nxt > cfg.high_threshold_mv;
  assign low_inc     = cur.low_ticks + TICKS_W'(1);
  assign ok_inc      = cur.ok_ticks + TICKS_W'(1);
  assign limit_ext   = {1'b0, cfg.debounce_limit};

  always_comb begin
    nxt            = cur;
    nxt.voltage_mv = volt_nxt;
    if (!item.in_flight) begin
      if (in_low_band) begin
        nxt.ok_ticks = '0;
        if (low_inc > limit_ext) begin
          nxt.low_ticks     = limit_ext;
          nxt.batt_low_flag = 1'b1;
        end else begin
          nxt.low_ticks = low_inc;
        end
      end else if (in_ok_band) begin
        nxt.low_ticks = '0;
        if (ok_inc > limit_ext) begin
          nxt.ok_ticks      = limit_ext;
          nxt.batt_low_flag = 1'b0;
        end else begin
          nxt.ok_ticks = ok_inc;
        end
      end else begin
        nxt.low_ticks = '0;
        nxt.ok_ticks  = '0;
      end
    end
  end

endmodule

// ===== design/battery_low_voltage_monitor_unit.sv =====
// Top level of the battery low-voltage monitor: handshake, configuration and state.
// Each transfer on the input channel is one converter tick and yields exactly one
// result transfer carrying the filtered voltage in millivolts and the low-power flag.
// A tick is captured in an input register and processed into the output register
// once that register is free or being drained; a held result keeps it staged. The
// unit sustains one tick per clock while the output is not stalled, since the single
// filter update between input and output register sets that rate. A held result
// stalls the input only while the input register is also full.
// Threshold and debounce registers are to be written by the user through the cfg_
// port only while no tick is in flight; the unit does not enforce it. Reset loads defaults.
module battery_low_voltage_monitor_unit import blvm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  mon_state_t state_r;
  mon_state_t state_nxt;
  logic       stage_valid_r;
  in_item_t   stage_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       advance;

  // The staged tick moves on whenever the output register is free or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = stage_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  blvm_step u_step (
    .item (stage_data_r),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold_mv  <= LOW_THR_RESET;
      cfg_r.high_threshold_mv <= HIGH_THR_RESET;
      cfg_r.floor_mv          <= FLOOR_RESET;
      cfg_r.debounce_limit    <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr_t'(cfg_addr))
        CFG_LOW_THRESHOLD:  cfg_r.low_threshold_mv  <= cfg_wdata[MV_W-1:0];
        CFG_HIGH_THRESHOLD: cfg_r.high_threshold_mv <= cfg_wdata[MV_W-1:0];
        CFG_FLOOR:          cfg_r.floor_mv          <= cfg_wdata[MV_W-1:0];
        CFG_DEBOUNCE_LIMIT: cfg_r.debounce_limit    <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.voltage_mv    <= VOLTAGE_RESET;
      state_r.low_ticks     <= '0;
      state_r.ok_ticks      <= '0;
      state_r.batt_low_flag <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= stage_valid_r;
        if (stage_valid_r) begin
          state_r <= state_nxt;
        end
      end
      if (!in_stall) begin
        stage_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_data_r <= in_data;
    end
    if (advance && stage_valid_r) begin
      out_data_r.filtered_mv <= state_nxt.voltage_mv;
      out_data_r.batt_low    <= state_nxt.batt_low_flag;
    end
  end

endmodule

// ===== test/tb_battery_low_voltage_monitor_unit.sv =====
// Self-checking testbench for the battery low-voltage monitor unit.
`timescale 1ns / 100ps

module tb_battery_low_voltage_monitor_unit import blvm_pkg::*; ();

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_MV      = 6598;
  localparam int RAND_TICKS  = 1500;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  cfg_addr_t             cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  battery_low_voltage_monitor_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the monitor: thresholds, filtered voltage, debounce counts and flag.
  cfg_t               cfg_shadow = '{LOW_THR_RESET, HIGH_THR_RESET, FLOOR_RESET,
                                     DEBOUNCE_RESET};
  logic [MV_W-1:0]    volt_mv    = VOLTAGE_RESET;
  logic [TICKS_W-1:0] low_cnt    = '0;
  logic [TICKS_W-1:0] ok_cnt     = '0;
  logic               lp_flag    = 1'b0;

  in_item_t  tick_q[$];
  out_item_t result_q[$];

  bit in_taken    = 1'b0;
  bit out_taken   = 1'b0;
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  bit hold_req    = 1'b0;
  int in_gap      = 0;
  int stall_left  = 0;
  int quiet       = 0;
  int n_errors    = 0;
  int rand_total  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_item_t filter_tick(in_item_t it);
    int        meas;
    int        diff;
    int        nv;
    out_item_t r;
    meas = 2 * int'((VREF_MV * it.adc_sample) >> SAMPLE_BITS);
    diff = meas - int'(volt_mv);
    // Division rounds toward minus infinity, so a falling voltage always moves.
    nv = int'(volt_mv) + ((diff >= 0) ? diff / 5 : -((-diff + 4) / 5));
    if (nv < 0) nv = 0;
    volt_mv = MV_W'(nv);
    if (!it.in_flight) begin
      if (volt_mv < cfg_shadow.low_threshold_mv && volt_mv > cfg_shadow.floor_mv) begin
        low_cnt = low_cnt + 1'b1;
        ok_cnt  = '0;
        if (low_cnt > cfg_shadow.debounce_limit) begin
          low_cnt = TICKS_W'(cfg_shadow.debounce_limit);
          lp_flag = 1'b1;
        end
      end else if (volt_mv > cfg_shadow.high_threshold_mv) begin
        ok_cnt  = ok_cnt + 1'b1;
        low_cnt = '0;
        if (ok_cnt > cfg_shadow.debounce_limit) begin
          ok_cnt  = TICKS_W'(cfg_shadow.debounce_limit);
          lp_flag = 1'b0;
        end
      end else begin
        low_cnt = '0;
        ok_cnt  = '0;
      end
    end
    r.filtered_mv = volt_mv;
    r.batt_low    = lp_flag;
    return r;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_gap(bit en);
    if (!en || $urandom_range(0, 99) < 50) return 0;
    return idle_len();
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] mv_to_sample(int mv);
    int s;
    s = (mv * 4096) / 6600;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return SAMPLE_BITS'(s);
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic push_tick(int s, bit flying);
    in_item_t it;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    it.adc_sample = SAMPLE_BITS'(s);
    it.in_flight  = flying;
    tick_q.push_back(it);
  endtask

  task automatic write_reg(cfg_addr_t a, int v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_cfg(int lo, int hi, int fl, int lim);
    write_reg(CFG_LOW_THRESHOLD, lo);
    write_reg(CFG_HIGH_THRESHOLD, hi);
    write_reg(CFG_FLOOR, fl);
    write_reg(CFG_DEBOUNCE_LIMIT, lim);
  endtask

  // Waits until every tick is taken and every result has come back, then lets
  // the two-stage pipeline settle before the thresholds may change.
  task automatic drain();
    while (tick_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Runs of ticks that hold a target voltage long enough for the filter to settle
  // and the debounce to act, with occasional raw noise and flying ticks mixed in.
  task automatic run_phase(int n);
    int left;
    int len;
    int lo;
    int hi;
    int tgt;
    int s;
    left = n;
    while (left > 0) begin
      case ($urandom_range(0, 4))
        0: begin lo = 0;                                  hi = cfg_shadow.floor_mv;          end
        1: begin lo = cfg_shadow.floor_mv + 1;            hi = cfg_shadow.low_threshold_mv - 1; end
        2: begin lo = cfg_shadow.low_threshold_mv;        hi = cfg_shadow.high_threshold_mv;  end
        3: begin lo = cfg_shadow.high_threshold_mv + 1;   hi = MAX_MV;                        end
        default: begin lo = 0;                            hi = MAX_MV;                        end
      endcase
      lo  = (lo < 0) ? 0 : (lo > MAX_MV) ? MAX_MV : lo;
      hi  = (hi < 0) ? 0 : (hi > MAX_MV) ? MAX_MV : hi;
      tgt = $urandom_range(hi, lo);
      len = $urandom_range(int'(cfg_shadow.debounce_limit) + 30, 3);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 4095);
        else s = int'(mv_to_sample(tgt)) + int'($urandom_range(0, 16)) - 8;
        push_tick(s, $urandom_range(0, 15) == 0);
      end
      left       -= len;
      rand_total += len;
    end
    drain();
  endtask

  // Sender: a new tick goes out only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_data  <= tick_q.pop_front();
        in_valid <= 1'b1;
        in_gap   = pick_gap(in_idle_en);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_idle_en && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Transfer tracking, prediction, result checking and the watchdog.
  always @(posedge clk) begin
    out_item_t want;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        CFG_LOW_THRESHOLD:  cfg_shadow.low_threshold_mv  = cfg_wdata;
        CFG_HIGH_THRESHOLD: cfg_shadow.high_threshold_mv = cfg_wdata;
        CFG_FLOOR:          cfg_shadow.floor_mv          = cfg_wdata;
        CFG_DEBOUNCE_LIMIT: cfg_shadow.debounce_limit    = cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
    if (in_taken) result_q.push_back(filter_tick(in_data));
    if (out_taken) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result transfer with none expected: mv=%0d lp=%0b",
                                  out_data.filtered_mv, out_data.batt_low));
      end else begin
        want = result_q.pop_front();
        if (out_data.filtered_mv !== want.filtered_mv)
          report_mismatch($sformatf("filtered_mv got %0d expected %0d",
                                    out_data.filtered_mv, want.filtered_mv));
        if (out_data.batt_low !== want.batt_low)
          report_mismatch($sformatf("batt_low got %0b expected %0b (mv %0d)",
                                    out_data.batt_low, want.batt_low, want.filtered_mv));
      end
    end
    if (in_taken || out_taken) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int fl;
    int lo;
    int hi;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_LOW_THRESHOLD;
    cfg_wdata = '0;
    clk       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset thresholds: sample extremes, both flight
    // states, and a walk through the below-floor, low, dead and ok bands.
    push_tick(0, 1'b0);
    push_tick(4095, 1'b0);
    push_tick(4095, 1'b1);
    push_tick(0, 1'b1);
    push_tick('h555, 1'b0);
    push_tick('hAAA, 1'b1);
    repeat (4) push_tick(mv_to_sample(3000), 1'b0);
    repeat (4) push_tick(mv_to_sample(3600), 1'b0);
    push_tick(mv_to_sample(3600), 1'b1);
    repeat (3) push_tick(mv_to_sample(3725), 1'b0);
    repeat (4) push_tick(mv_to_sample(4500), 1'b0);
    drain();
    run_phase(250);

    // Shortest regular debounce.
    set_cfg(3700, 3750, 3400, 1);
    run_phase(200);

    // Overlapping thresholds at the extremes: the low band takes precedence.
    set_cfg(MAX_MV, 0, 0, 127);
    run_phase(250);

    // No voltage can fall into either band.
    set_cfg(0, MAX_MV, MAX_MV, 1);
    run_phase(40);

    // A debounce limit of zero acts on the first tick, here with no idling at all.
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    set_cfg(4000, 4200, 3000, 0);
    run_phase(100);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    // Build up a low count, then lower the limit beneath it.
    set_cfg(5000, 5200, 1000, 127);
    repeat (60) push_tick(mv_to_sample(3000), 1'b0);
    drain();
    write_reg(CFG_DEBOUNCE_LIMIT, 3);
    repeat (5) push_tick(mv_to_sample(3000), 1'b0);
    run_phase(60);

    // Long receiver hold-off while the sender keeps offering ticks back to back.
    set_cfg(3700, 3800, 3300, 8);
    in_idle_en = 1'b0;
    hold_req   = 1'b1;
    run_phase(150);
    in_idle_en = 1'b1;

    while (rand_total < RAND_TICKS) begin
      fl = $urandom_range(0, 4500);
      lo = fl + $urandom_range(0, 1500);
      hi = lo + $urandom_range(0, 300);
      set_cfg(lo, hi, fl, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127)
                                                      : $urandom_range(1, 12));
      in_idle_en  = $urandom_range(0, 3) != 0;
      out_idle_en = $urandom_range(0, 3) != 0;
      run_phase(150);
    end

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
